[design/assert_macros.svh]
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset.
`define RTN_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Checked on every edge, reset included.
`define RTN_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

[design/rtn_pkg.sv]
package rtn_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MAT_BITS      = 10;
  localparam int MAT_W         = 10;
  localparam logic [MAT_W-1:0] MAT_MASK = MAT_W'((64'd1 << MAT_BITS) - 64'd1);

  localparam logic signed [31:0] WORD_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] WORD_MIN = 32'sh80000000;

  typedef logic signed [31:0] word_t;
  typedef logic signed [32:0] opnd_t;
  typedef logic signed [65:0] acc_t;

  localparam logic [2:0] REG_START_X = 3'd0;
  localparam logic [2:0] REG_START_Y = 3'd1;
  localparam logic [2:0] REG_START_Z = 3'd2;
  localparam logic [2:0] REG_END_X   = 3'd3;
  localparam logic [2:0] REG_END_Y   = 3'd4;
  localparam logic [2:0] REG_END_Z   = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE, S_PSQ, S_PSQRT, S_PDIV, S_NRM, S_CULL, S_DIST,
    S_TDIV, S_HITP, S_EDIFF, S_ECROSS, S_EDOT, S_DONE
  } st_t;

  typedef struct packed {
    logic issue;
    logic clr;
    logic sub;
    logic shf;
  } mac_op_t;

  typedef struct packed {
    logic start;
    logic sqrt;
  } iter_cmd_t;

  function automatic word_t sat_acc(input acc_t v);
    word_t r;
    if (!v[65] && (|v[64:31])) begin
      r = WORD_MAX;
    end else if (v[65] && !(&v[64:31])) begin
      r = WORD_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic word_t sat_diff(input word_t x, input word_t y);
    logic signed [32:0] d;
    word_t r;
    d = {x[31], x} - {y[31], y};
    if (d[32] != d[31]) begin
      r = d[32] ? WORD_MIN : WORD_MAX;
    end else begin
      r = d[31:0];
    end
    return r;
  endfunction

  function automatic opnd_t sx33(input word_t w);
    return {w[31], w};
  endfunction

  function automatic logic [1:0] rot1(input logic [1:0] i);
    logic [1:0] r;
    case (i)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] rot2(input logic [1:0] i);
    logic [1:0] r;
    case (i)
      2'd0:    r = 2'd2;
      2'd1:    r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

endpackage

[design/rtn_mac.sv]
module rtn_mac #(
  parameter int FRAC_BITS = rtn_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  rtn_pkg::mac_op_t op,
  input  rtn_pkg::opnd_t   a,
  input  rtn_pkg::opnd_t   b,
  input  rtn_pkg::acc_t    init,
  output rtn_pkg::acc_t    acc
);

  rtn_pkg::acc_t prod;
  rtn_pkg::acc_t p;
  rtn_pkg::acc_t init_d;
  rtn_pkg::acc_t sh;
  rtn_pkg::acc_t acc_next;
  logic          pv;
  logic          clr_d;
  logic          sub_d;
  logic          shf_d;

  assign prod = a * b;
  assign sh = shf_d ? (p >>> FRAC_BITS) : p;
  assign acc_next = (clr_d ? init_d : acc) + (sub_d ? -sh : sh);

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= op.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (op.issue) begin
      p      <= prod;
      clr_d  <= op.clr;
      sub_d  <= op.sub;
      shf_d  <= op.shf;
      init_d <= init;
    end
    if (pv) begin
      acc <= acc_next;
    end
  end

endmodule

[design/rtn_iter.sv]
module rtn_iter (
  input  logic               clk,
  input  logic               rst,
  input  rtn_pkg::iter_cmd_t cmd,
  input  logic [32:0]        rem_init,
  input  logic [63:0]        src_init,
  input  logic [32:0]        den,
  output logic [31:0]        q,
  output logic               done
);

  localparam int STEPS = 32;

  logic [34:0] rem;
  logic [63:0] src;
  logic [32:0] den_r;
  logic [4:0]  cnt;
  logic        busy;
  logic        sqrt_m;
  logic [34:0] x;
  logic [34:0] y;
  logic        ge;

  assign x  = sqrt_m ? {rem[32:0], src[63:62]} : {rem[33:0], src[63]};
  assign y  = sqrt_m ? {1'b0, q, 2'b01} : {2'b00, den_r};
  assign ge = (x >= y);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (cmd.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 5'(STEPS - 1));
      if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem    <= {2'b00, rem_init};
      src    <= src_init;
      den_r  <= den;
      q      <= '0;
      sqrt_m <= cmd.sqrt;
    end else if (busy) begin
      rem <= ge ? (x - y) : x;
      q   <= {q[30:0], ge};
      src <= sqrt_m ? {src[61:0], 2'b00} : {src[62:0], 1'b0};
    end
  end

endmodule

[design/ray_triangle_nearest_hit.sv]
// channel  dir  handshake          payload
// cfg      in   cfg_valid/ready    cfg_index, cfg_data
// in       in   in_valid/stall     vert_a_* .. vert_c_*, material, last_face
// out      out  out_valid/stall    hit, hit_material, hit_pos_*, hit_norm_*, hit_dist
// First triangle of a query also sets up the ray (squares, 32-step square root and, for a
// nonzero length, three 32-step divides). Each triangle then takes one term per cycle through
// the shared multiplier and, unless culled or out of range, a 32-step divide for the distance.
// in_stall is high while a triangle is worked on; a result waits in the output register.
// rst is synchronous and clears the configuration and the query.
module ray_triangle_nearest_hit #(
  parameter int FRAC_BITS = rtn_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] vert_a_x,
  input  logic signed [31:0] vert_a_y,
  input  logic signed [31:0] vert_a_z,
  input  logic signed [31:0] vert_b_x,
  input  logic signed [31:0] vert_b_y,
  input  logic signed [31:0] vert_b_z,
  input  logic signed [31:0] vert_c_x,
  input  logic signed [31:0] vert_c_y,
  input  logic signed [31:0] vert_c_z,
  input  logic [9:0]         material,
  input  logic               last_face,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hit,
  output logic [9:0]         hit_material,
  output logic signed [31:0] hit_pos_x,
  output logic signed [31:0] hit_pos_y,
  output logic signed [31:0] hit_pos_z,
  output logic signed [31:0] hit_norm_x,
  output logic signed [31:0] hit_norm_y,
  output logic signed [31:0] hit_norm_z,
  output logic [30:0]        hit_dist
);

  rtn_pkg::st_t  st;
  rtn_pkg::st_t  st_next;
  logic [2:0]    k;
  logic [1:0]    comp;
  logic [1:0]    edge_i;
  logic          query_open;
  logic          any_hit;

  rtn_pkg::word_t cfg_s [3];
  rtn_pkg::word_t cfg_e [3];
  rtn_pkg::word_t pa [3];
  rtn_pkg::word_t pb [3];
  rtn_pkg::word_t pc [3];
  rtn_pkg::word_t va [3];
  rtn_pkg::word_t vb [3];
  rtn_pkg::word_t vc [3];
  rtn_pkg::word_t ab [3];
  rtn_pkg::word_t bc [3];
  rtn_pkg::word_t ca [3];
  rtn_pkg::word_t rel_a [3];
  rtn_pkg::word_t rv [3];
  rtn_pkg::word_t udir [3];
  rtn_pkg::word_t nrm [3];
  rtn_pkg::word_t cp [3];
  rtn_pkg::word_t dd [3];
  rtn_pkg::word_t tc [3];
  rtn_pkg::word_t bpos [3];
  rtn_pkg::word_t bnorm [3];
  rtn_pkg::word_t vsel [3];
  rtn_pkg::word_t evec [3];
  rtn_pkg::word_t uvec [3];
  rtn_pkg::word_t wvec [3];
  logic [rtn_pkg::MAT_W-1:0] mat;
  logic [rtn_pkg::MAT_W-1:0] bmat;
  logic          last_r;
  logic [31:0]   len_r;
  logic [30:0]   near;
  logic [32:0]   den_r;
  logic [31:0]   t_r;

  rtn_pkg::mac_op_t   mop;
  rtn_pkg::opnd_t     opa;
  rtn_pkg::opnd_t     opb;
  rtn_pkg::acc_t      init;
  rtn_pkg::acc_t      acc;
  rtn_pkg::acc_t      negacc;
  rtn_pkg::iter_cmd_t icmd;
  logic [32:0]   it_rem;
  logic [63:0]   it_src;
  logic [32:0]   it_den;
  logic [31:0]   iter_q;
  logic          iter_done;

  logic [2:0]    n_terms;
  logic          grp_end;
  logic [1:0]    kidx;
  logic [1:0]    ia;
  logic [1:0]    ib;
  logic [63:0]   num_t;
  logic [32:0]   mag_n;
  logic [63:0]   num_p;
  logic          cull_rej;
  logic          dist_rej;
  logic          t_rej;
  logic          edge_rej;
  logic          accept;
  logic          out_free;
  logic          out_load;

  rtn_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk(clk), .rst(rst), .op(mop), .a(opa), .b(opb), .init(init), .acc(acc)
  );

  rtn_iter u_iter (
    .clk(clk), .rst(rst), .cmd(icmd), .rem_init(it_rem), .src_init(it_src),
    .den(it_den), .q(iter_q), .done(iter_done)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (st != rtn_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = (st == rtn_pkg::S_DONE) && last_r && out_free;

  assign pa[0] = vert_a_x;
  assign pa[1] = vert_a_y;
  assign pa[2] = vert_a_z;
  assign pb[0] = vert_b_x;
  assign pb[1] = vert_b_y;
  assign pb[2] = vert_b_z;
  assign pc[0] = vert_c_x;
  assign pc[1] = vert_c_y;
  assign pc[2] = vert_c_z;

  always_comb begin
    case (st)
      rtn_pkg::S_PSQ, rtn_pkg::S_CULL, rtn_pkg::S_DIST, rtn_pkg::S_EDOT: n_terms = 3'd3;
      rtn_pkg::S_NRM, rtn_pkg::S_ECROSS:                                 n_terms = 3'd2;
      rtn_pkg::S_HITP:                                                   n_terms = 3'd1;
      default:                                                           n_terms = 3'd0;
    endcase
  end

  assign grp_end = (n_terms != 3'd0) && (k == n_terms + 3'd1);
  assign kidx    = (k[1:0] == 2'd3) ? 2'd0 : k[1:0];
  assign ia      = (k == 3'd0) ? rtn_pkg::rot1(comp) : rtn_pkg::rot2(comp);
  assign ib      = (k == 3'd0) ? rtn_pkg::rot2(comp) : rtn_pkg::rot1(comp);

  assign negacc   = -acc;
  assign num_t    = negacc[63:0] << FRAC_BITS;
  assign mag_n    = rv[comp][31] ? -{rv[comp][31], rv[comp]} : {1'b0, rv[comp]};
  assign num_p    = {32'd0, mag_n[31:0]} << FRAC_BITS;
  assign cull_rej = !acc[65];
  assign dist_rej = (!acc[65] && (|acc)) || ({1'b0, num_t[63:32]} >= den_r);
  assign t_rej    = iter_q > {1'b0, near};
  assign edge_rej = acc[65];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (edge_i)
        2'd0: begin
          vsel[i] = va[i];
          evec[i] = ab[i];
        end
        2'd1: begin
          vsel[i] = vb[i];
          evec[i] = bc[i];
        end
        default: begin
          vsel[i] = vc[i];
          evec[i] = ca[i];
        end
      endcase
      uvec[i] = (st == rtn_pkg::S_NRM) ? ab[i] : dd[i];
      wvec[i] = (st == rtn_pkg::S_NRM) ? bc[i] : evec[i];
    end
  end

  always_comb begin
    st_next = st;
    case (st)
      rtn_pkg::S_IDLE: begin
        if (accept) begin
          st_next = query_open ? rtn_pkg::S_NRM : rtn_pkg::S_PSQ;
        end
      end
      rtn_pkg::S_PSQ: begin
        if (grp_end) begin
          st_next = rtn_pkg::S_PSQRT;
        end
      end
      rtn_pkg::S_PSQRT: begin
        if (iter_done) begin
          st_next = (iter_q == 32'd0) ? rtn_pkg::S_NRM : rtn_pkg::S_PDIV;
        end
      end
      rtn_pkg::S_PDIV: begin
        if (k != 3'd0 && iter_done && comp == 2'd2) begin
          st_next = rtn_pkg::S_NRM;
        end
      end
      rtn_pkg::S_NRM: begin
        if (grp_end && comp == 2'd2) begin
          st_next = rtn_pkg::S_CULL;
        end
      end
      rtn_pkg::S_CULL: begin
        if (grp_end) begin
          st_next = cull_rej ? rtn_pkg::S_DONE : rtn_pkg::S_DIST;
        end
      end
      rtn_pkg::S_DIST: begin
        if (grp_end) begin
          st_next = dist_rej ? rtn_pkg::S_DONE : rtn_pkg::S_TDIV;
        end
      end
      rtn_pkg::S_TDIV: begin
        if (iter_done) begin
          st_next = t_rej ? rtn_pkg::S_DONE : rtn_pkg::S_HITP;
        end
      end
      rtn_pkg::S_HITP: begin
        if (grp_end && comp == 2'd2) begin
          st_next = rtn_pkg::S_EDIFF;
        end
      end
      rtn_pkg::S_EDIFF: begin
        st_next = rtn_pkg::S_ECROSS;
      end
      rtn_pkg::S_ECROSS: begin
        if (grp_end && comp == 2'd2) begin
          st_next = rtn_pkg::S_EDOT;
        end
      end
      rtn_pkg::S_EDOT: begin
        if (grp_end) begin
          st_next = (edge_rej || edge_i == 2'd2) ? rtn_pkg::S_DONE : rtn_pkg::S_EDIFF;
        end
      end
      rtn_pkg::S_DONE: begin
        if (!last_r || out_free) begin
          st_next = rtn_pkg::S_IDLE;
        end
      end
      default: st_next = rtn_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mop       = '0;
    mop.issue = (n_terms != 3'd0) && (k < n_terms);
    mop.clr   = (k == 3'd0);
    mop.shf   = 1'b1;
    opa       = '0;
    opb       = '0;
    init      = '0;
    icmd      = '0;
    it_rem    = '0;
    it_src    = '0;
    it_den    = '0;
    case (st)
      rtn_pkg::S_PSQ: begin
        mop.shf = 1'b0;
        opa     = rtn_pkg::sx33(rv[kidx]);
        opb     = rtn_pkg::sx33(rv[kidx]);
        if (grp_end) begin
          icmd.start = 1'b1;
          icmd.sqrt  = 1'b1;
          it_src     = acc[63:0];
        end
      end
      rtn_pkg::S_PDIV: begin
        if (k == 3'd0) begin
          icmd.start = 1'b1;
          it_rem     = {1'b0, num_p[63:32]};
          it_src     = {num_p[31:0], 32'd0};
          it_den     = {1'b0, len_r};
        end
      end
      rtn_pkg::S_NRM, rtn_pkg::S_ECROSS: begin
        mop.sub = (k != 3'd0);
        opa     = rtn_pkg::sx33(uvec[ia]);
        opb     = rtn_pkg::sx33(wvec[ib]);
      end
      rtn_pkg::S_CULL: begin
        opa = rtn_pkg::sx33(udir[kidx]);
        opb = rtn_pkg::sx33(nrm[kidx]);
      end
      rtn_pkg::S_DIST: begin
        opa = rtn_pkg::sx33(rel_a[kidx]);
        opb = rtn_pkg::sx33(nrm[kidx]);
        if (grp_end && !dist_rej) begin
          icmd.start = 1'b1;
          it_rem     = {1'b0, num_t[63:32]};
          it_src     = {num_t[31:0], 32'd0};
          it_den     = den_r;
        end
      end
      rtn_pkg::S_HITP: begin
        opa  = rtn_pkg::sx33(udir[comp]);
        opb  = {1'b0, t_r};
        init = {{34{cfg_s[comp][31]}}, cfg_s[comp]};
      end
      rtn_pkg::S_EDOT: begin
        opa = rtn_pkg::sx33(tc[kidx]);
        opb = rtn_pkg::sx33(nrm[kidx]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= rtn_pkg::S_IDLE;
      k          <= '0;
      comp       <= '0;
      edge_i     <= '0;
      query_open <= 1'b0;
      any_hit    <= 1'b0;
      out_valid  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        cfg_s[i] <= '0;
        cfg_e[i] <= '0;
      end
    end else begin
      st <= st_next;
      if (st != st_next) begin
        k    <= '0;
        comp <= '0;
      end else if (n_terms != 3'd0) begin
        k <= grp_end ? 3'd0 : k + 3'd1;
        if (grp_end) begin
          comp <= comp + 2'd1;
        end
      end else if (st == rtn_pkg::S_PDIV) begin
        if (k == 3'd0) begin
          k <= 3'd1;
        end else if (iter_done) begin
          k    <= 3'd0;
          comp <= comp + 2'd1;
        end
      end
      if (accept) begin
        edge_i <= '0;
        if (!query_open) begin
          query_open <= 1'b1;
          any_hit    <= 1'b0;
        end
      end
      if (st == rtn_pkg::S_EDOT && grp_end && !edge_rej) begin
        edge_i <= edge_i + 2'd1;
        if (edge_i == 2'd2) begin
          any_hit <= 1'b1;
        end
      end
      if (out_load) begin
        query_open <= 1'b0;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rtn_pkg::REG_START_X: cfg_s[0] <= cfg_data;
          rtn_pkg::REG_START_Y: cfg_s[1] <= cfg_data;
          rtn_pkg::REG_START_Z: cfg_s[2] <= cfg_data;
          rtn_pkg::REG_END_X:   cfg_e[0] <= cfg_data;
          rtn_pkg::REG_END_Y:   cfg_e[1] <= cfg_data;
          rtn_pkg::REG_END_Z:   cfg_e[2] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        va[i]    <= pa[i];
        vb[i]    <= pb[i];
        vc[i]    <= pc[i];
        ab[i]    <= rtn_pkg::sat_diff(pb[i], pa[i]);
        bc[i]    <= rtn_pkg::sat_diff(pc[i], pb[i]);
        ca[i]    <= rtn_pkg::sat_diff(pa[i], pc[i]);
        rel_a[i] <= rtn_pkg::sat_diff(pa[i], cfg_s[i]);
        if (!query_open) begin
          rv[i]    <= rtn_pkg::sat_diff(cfg_e[i], cfg_s[i]);
          bpos[i]  <= '0;
          bnorm[i] <= '0;
        end
      end
      if (!query_open) begin
        bmat <= '0;
      end
      mat    <= material & rtn_pkg::MAT_MASK;
      last_r <= last_face;
    end
    if (st == rtn_pkg::S_PSQRT && iter_done) begin
      len_r <= iter_q;
      near  <= iter_q[31] ? 31'h7FFFFFFF : iter_q[30:0];
      if (iter_q == 32'd0) begin
        for (int i = 0; i < 3; i++) begin
          udir[i] <= '0;
        end
      end
    end
    if (st == rtn_pkg::S_PDIV && k != 3'd0 && iter_done) begin
      udir[comp] <= rv[comp][31] ? -iter_q : iter_q;
    end
    if (st == rtn_pkg::S_NRM && grp_end) begin
      nrm[comp] <= rtn_pkg::sat_acc(acc);
    end
    if (st == rtn_pkg::S_CULL && grp_end) begin
      den_r <= negacc[32:0];
    end
    if (st == rtn_pkg::S_TDIV && iter_done) begin
      t_r <= iter_q;
    end
    if (st == rtn_pkg::S_HITP && grp_end) begin
      cp[comp] <= rtn_pkg::sat_acc(acc);
    end
    if (st == rtn_pkg::S_EDIFF) begin
      for (int i = 0; i < 3; i++) begin
        dd[i] <= rtn_pkg::sat_diff(vsel[i], cp[i]);
      end
    end
    if (st == rtn_pkg::S_ECROSS && grp_end) begin
      tc[comp] <= rtn_pkg::sat_acc(acc);
    end
    if (st == rtn_pkg::S_EDOT && grp_end && !edge_rej && edge_i == 2'd2) begin
      for (int i = 0; i < 3; i++) begin
        bpos[i]  <= cp[i];
        bnorm[i] <= nrm[i];
      end
      bmat <= mat;
      near <= t_r[30:0];
    end
    if (out_load) begin
      hit          <= any_hit;
      hit_material <= bmat;
      hit_pos_x    <= bpos[0];
      hit_pos_y    <= bpos[1];
      hit_pos_z    <= bpos[2];
      hit_norm_x   <= bnorm[0];
      hit_norm_y   <= bnorm[1];
      hit_norm_z   <= bnorm[2];
      hit_dist     <= near;
    end
  end

endmodule

[design/rtn_chk.sv]
`include "assert_macros.svh"

module rtn_chk (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               hit,
  input logic [9:0]         hit_material,
  input logic signed [31:0] hit_pos_x,
  input logic signed [31:0] hit_pos_y,
  input logic signed [31:0] hit_pos_z,
  input logic signed [31:0] hit_norm_x,
  input logic [30:0]        hit_dist
);

  `RTN_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(hit_dist), "stalled result changed")
  `RTN_ASSERT(a_busy_after_item, clk, rst, in_valid && !in_stall |=> in_stall, "item not held busy")
  `RTN_ASSERT(a_miss_zero, clk, rst, out_valid && !hit |-> hit_material == 10'd0 && hit_pos_x == 32'sd0 && hit_pos_y == 32'sd0 && hit_pos_z == 32'sd0 && hit_norm_x == 32'sd0, "miss result not zero")
  `RTN_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid && !in_stall, "reset did not idle block")

endmodule

bind ray_triangle_nearest_hit rtn_chk u_rtn_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .hit(hit),
  .hit_material(hit_material), .hit_pos_x(hit_pos_x), .hit_pos_y(hit_pos_y),
  .hit_pos_z(hit_pos_z), .hit_norm_x(hit_norm_x), .hit_dist(hit_dist)
);

[sim/tb_ray_triangle_nearest_hit.sv]
module tb_ray_triangle_nearest_hit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint LMAX = 64'sd2147483647;
  localparam longint LMIN = -64'sd2147483648;
  localparam longint U = 64'sd65536;
  localparam int N_ITEMS = 800;

  typedef struct {
    longint v[9];
    bit [9:0] mat;
    bit last;
  } tri_t;

  typedef struct {
    bit hit;
    bit [9:0] mat;
    longint pos[3];
    longint nrm[3];
    longint dst;
  } hit_t;

  typedef struct {
    tri_t t;
    bit set_ray;
    longint ray[6];
    bit zero_exp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = rtn_pkg::REG_START_X;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  rtn_pkg::word_t vert_a_x = '0, vert_a_y = '0, vert_a_z = '0;
  rtn_pkg::word_t vert_b_x = '0, vert_b_y = '0, vert_b_z = '0;
  rtn_pkg::word_t vert_c_x = '0, vert_c_y = '0, vert_c_z = '0;
  logic [9:0] material = '0;
  logic last_face = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit;
  logic [9:0] hit_material;
  rtn_pkg::word_t hit_pos_x, hit_pos_y, hit_pos_z;
  rtn_pkg::word_t hit_norm_x, hit_norm_y, hit_norm_z;
  logic [30:0] hit_dist;

  ray_triangle_nearest_hit u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  longint ray_cfg[6];
  longint dir_u[3];
  longint near_d;
  longint best_p[3];
  longint best_n[3];
  bit [9:0] best_m;
  bit any_h;
  bit open_q;

  hit_t hit_q[$];
  int errs = 0;
  int sent = 0;
  int seen = 0;
  bit calm = 0;

  function automatic longint sat32(longint v);
    if (v > LMAX) return LMAX;
    if (v < LMIN) return LMIN;
    return v;
  endfunction

  function automatic longint fmul(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> 16;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic void cross3(input longint u[3], input longint w[3], output longint r[3]);
    r[0] = sat32(fmul(u[1], w[2]) - fmul(u[2], w[1]));
    r[1] = sat32(fmul(u[2], w[0]) - fmul(u[0], w[2]));
    r[2] = sat32(fmul(u[0], w[1]) - fmul(u[1], w[0]));
  endfunction

  function automatic longint dot3(input longint u[3], input longint w[3]);
    return fmul(u[0], w[0]) + fmul(u[1], w[1]) + fmul(u[2], w[2]);
  endfunction

  function automatic bit edge_in(input longint vx[3], input longint cp[3],
                                 input longint e[3], input longint n[3]);
    longint d[3], r[3];
    for (int i = 0; i < 3; i++) d[i] = sat32(vx[i] - cp[i]);
    cross3(d, e, r);
    return dot3(r, n) >= 0;
  endfunction

  function automatic void set_up_ray();
    longint v[3];
    longint unsigned sum, len, m, q;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      v[i] = sat32(ray_cfg[3+i] - ray_cfg[i]);
      m = v[i] < 0 ? -v[i] : v[i];
      sum += m * m;
    end
    len = isqrt(sum);
    for (int i = 0; i < 3; i++) begin
      if (len == 0) begin
        dir_u[i] = 0;
      end else begin
        m = v[i] < 0 ? -v[i] : v[i];
        q = (m << 16) / len;
        dir_u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      best_p[i] = 0;
      best_n[i] = 0;
    end
    near_d = len > 64'd2147483647 ? LMAX : longint'(len);
    best_m = 0;
    any_h = 0;
    open_q = 1;
  endfunction

  function automatic void test_tri(tri_t t);
    longint a[3], b[3], c[3], ab[3], bc[3], ca[3], n[3], as_[3], cp[3];
    longint dt, d1;
    longint unsigned num, den, tq;
    for (int i = 0; i < 3; i++) begin
      a[i] = t.v[i];
      b[i] = t.v[3+i];
      c[i] = t.v[6+i];
    end
    for (int i = 0; i < 3; i++) begin
      ab[i] = sat32(b[i] - a[i]);
      bc[i] = sat32(c[i] - b[i]);
      ca[i] = sat32(a[i] - c[i]);
      as_[i] = sat32(a[i] - ray_cfg[i]);
    end
    cross3(ab, bc, n);
    dt = dot3(dir_u, n);
    if (dt >= 0) return;
    d1 = dot3(as_, n);
    if (d1 > 0) return;
    num = -d1;
    num = num << 16;
    den = -dt;
    tq = num / den;
    if (tq > longint'(near_d)) return;
    for (int i = 0; i < 3; i++) cp[i] = sat32(ray_cfg[i] + fmul(dir_u[i], longint'(tq)));
    if (!edge_in(a, cp, ab, n)) return;
    if (!edge_in(b, cp, bc, n)) return;
    if (!edge_in(c, cp, ca, n)) return;
    for (int i = 0; i < 3; i++) begin
      best_p[i] = cp[i];
      best_n[i] = n[i];
    end
    best_m = t.mat;
    near_d = longint'(tq);
    any_h = 1;
  endfunction

  // returns 1 and the query result when the triangle closes the query
  function automatic bit query_step(tri_t t, output hit_t r);
    if (!open_q) set_up_ray();
    test_tri(t);
    r.hit = any_h;
    r.mat = best_m;
    for (int i = 0; i < 3; i++) begin
      r.pos[i] = best_p[i];
      r.nrm[i] = best_n[i];
    end
    r.dst = near_d;
    if (t.last) open_q = 0;
    return t.last;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (hit_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_ray(longint r[6]);
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= rtn_pkg::REG_START_X + 3'(i);
      cfg_data <= 32'(r[i]);
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      ray_cfg[i] = longint'(rtn_pkg::word_t'(r[i]));
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_tri(tri_t t, bit zero_exp);
    hit_t r;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    vert_a_x <= 32'(t.v[0]); vert_a_y <= 32'(t.v[1]); vert_a_z <= 32'(t.v[2]);
    vert_b_x <= 32'(t.v[3]); vert_b_y <= 32'(t.v[4]); vert_b_z <= 32'(t.v[5]);
    vert_c_x <= 32'(t.v[6]); vert_c_y <= 32'(t.v[7]); vert_c_z <= 32'(t.v[8]);
    material <= t.mat;
    last_face <= t.last;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (query_step(t, r)) begin
      if (zero_exp) r = '{default: 0};
      hit_q.push_back(r);
    end
  endtask

  function automatic tri_t flat_tri(longint cx, longint cy, longint z, bit flip,
                                    bit [9:0] m, bit lst);
    tri_t t;
    t.v = '{cx - U, cy - U, z, cx, cy + U, z, cx + U, cy - U, z};
    if (flip) t.v = '{cx - U, cy - U, z, cx + U, cy - U, z, cx, cy + U, z};
    t.mat = m;
    t.last = lst;
    return t;
  endfunction

  function automatic tri_t fill_tri(longint val, bit [9:0] m);
    tri_t t;
    t.v = '{default: val};
    t.mat = m;
    t.last = 1;
    return t;
  endfunction

  function automatic longint srand(int lo, int hi);
    return longint'(int'($urandom_range(0, hi - lo)) + lo);
  endfunction

  task automatic check_result();
    hit_t e;
    longint got_p[3], got_n[3];
    got_p = '{longint'(hit_pos_x), longint'(hit_pos_y), longint'(hit_pos_z)};
    got_n = '{longint'(hit_norm_x), longint'(hit_norm_y), longint'(hit_norm_z)};
    if (hit_q.size() == 0) begin
      $display("%0t unexpected result item", $time);
      errs++;
      return;
    end
    e = hit_q.pop_front();
    seen++;
    if (e.hit != hit) begin
      $display("%0t hit expected %0d actual %0d", $time, e.hit, hit);
      errs++;
    end
    if (e.mat != hit_material) begin
      $display("%0t hit_material expected %0d actual %0d", $time, e.mat, hit_material);
      errs++;
    end
    for (int i = 0; i < 3; i++) begin
      if (e.pos[i] != got_p[i]) begin
        $display("%0t hit_pos[%0d] expected %0d actual %0d", $time, i, e.pos[i], got_p[i]);
        errs++;
      end
      if (e.nrm[i] != got_n[i]) begin
        $display("%0t hit_norm[%0d] expected %0d actual %0d", $time, i, e.nrm[i], got_n[i]);
        errs++;
      end
    end
    if (31'(e.dst) != hit_dist) begin
      $display("%0t hit_dist expected %0d actual %0d", $time, e.dst, hit_dist);
      errs++;
    end
  endtask

  // result side
  initial begin
    int burst;
    int hold;
    bit held;
    burst = 0;
    hold = 0;
    held = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) check_result();
      if (hold > 0) begin
        hold--;
        out_stall <= (hold != 0);
      end else if (!held && seen == 40) begin
        held = 1;
        hold = 3000;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= (burst != 0);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 6);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    row_t rows[$];
    row_t rw;
    tri_t t;
    longint ray[6], p[3], d[3];
    longint r1, r2, r3, r4, dz;
    int nq, k;

    ray_cfg = '{default: 0};
    dir_u = '{default: 0};
    best_p = '{default: 0};
    best_n = '{default: 0};
    near_d = 0;
    best_m = 0;
    any_h = 0;
    open_q = 0;

    // zero-length ray after reset: everything culled
    rw = '{default: 0};
    rw.zero_exp = 1;
    rw.t = fill_tri(LMAX, 10'h3FF); rows.push_back(rw);
    rw.t = fill_tri(LMIN, 10'h000); rows.push_back(rw);
    rw.t = flat_tri(0, 0, 0, 0, 10'h2AA, 1); rows.push_back(rw);
    // ray along +z from -10 to +10
    rw = '{default: 0};
    rw.set_ray = 1;
    rw.ray = '{0, 0, -10 * U, 0, 0, 10 * U};
    rw.t = flat_tri(0, 0, 0, 0, 5, 0); rows.push_back(rw);
    rw.set_ray = 0;
    rw.t = flat_tri(0, 0, 0, 0, 6, 1); rows.push_back(rw);        // tie
    rw.t = flat_tri(0, 0, 0, 1, 7, 1); rows.push_back(rw);        // back face
    rw.t = flat_tri(0, 0, -20 * U, 0, 8, 1); rows.push_back(rw);  // behind start
    rw.t = fill_tri(3 * U, 9); rows.push_back(rw);                // degenerate
    rw.t = flat_tri(0, 0, 15 * U, 0, 10, 1); rows.push_back(rw);  // past the end
    rw.t = flat_tri(0, 0, 5 * U, 0, 11, 0); rows.push_back(rw);
    rw.t = flat_tri(0, 0, -5 * U, 0, 12, 1); rows.push_back(rw);  // nearer second
    rw.t = flat_tri(100 * U, 0, 0, 0, 13, 1); rows.push_back(rw); // miss
    // extreme ray
    rw.set_ray = 1;
    rw.ray = '{LMIN, LMIN, LMIN, LMAX, LMAX, LMAX};
    rw.t = fill_tri(LMAX, 10'h3FF); rows.push_back(rw);
    rw.set_ray = 0;
    rw.t = fill_tri(LMIN, 1); rows.push_back(rw);
    rw.t = flat_tri(0, 0, 0, 0, 14, 1); rows.push_back(rw);
    rw.t.v = '{LMIN, LMAX, 0, LMAX, LMIN, LMAX, 0, LMAX, LMIN};
    rows.push_back(rw);
    rw.set_ray = 1;
    rw.ray = '{LMAX, LMAX, LMAX, LMIN, LMIN, LMIN};
    rw.t = flat_tri(0, 0, 0, 1, 15, 1); rows.push_back(rw);
    rw.set_ray = 0;
    rw.t.v = '{LMAX, LMIN, LMAX, LMIN, LMAX, LMIN, LMAX, LMAX, LMIN};
    rows.push_back(rw);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].set_ray) begin
        wait_drained();
        write_ray(rows[i].ray);
      end
      send_tri(rows[i].t, rows[i].zero_exp);
    end

    while (sent < N_ITEMS) begin
      wait_drained();
      if ($urandom_range(0, 5) == 0) begin
        foreach (ray[i]) ray[i] = longint'(int'($urandom()));
      end else begin
        for (int i = 0; i < 3; i++) ray[i] = srand(-1600, 1600) * U / 8;
        ray[3] = ray[0] + srand(-8, 8) * U;
        ray[4] = ray[1] + srand(-8, 8) * U;
        dz = srand(50, 400) * U;
        ray[5] = ray[2] + ($urandom_range(0, 1) ? dz : -dz);
      end
      write_ray(ray);
      for (int i = 0; i < 3; i++) d[i] = ray[3+i] - ray[i];
      nq = $urandom_range(4, 10);
      for (int q = 0; q < nq && sent < N_ITEMS; q++) begin
        k = $urandom_range(1, 6);
        for (int j = 0; j < k; j++) begin
          if ($urandom_range(0, 6) == 0) begin
            foreach (t.v[i]) t.v[i] = longint'(int'($urandom()));
          end else begin
            for (int i = 0; i < 3; i++) p[i] = ray[i] + d[i] * srand(-1, 17) / 16;
            r1 = srand(1, 80) * U / 4;
            r2 = srand(1, 80) * U / 4;
            r3 = srand(1, 80) * U / 4;
            r4 = srand(1, 80) * U / 4;
            t.v[0] = p[0] - r1;  t.v[1] = p[1] - r2;
            t.v[3] = p[0] + srand(-4, 4) * U / 8;  t.v[4] = p[1] + r3;
            t.v[6] = p[0] + r4;  t.v[7] = p[1] - r1;
            t.v[2] = p[2] + srand(-16, 16) * U / 8;
            t.v[5] = p[2] + srand(-16, 16) * U / 8;
            t.v[8] = p[2] + srand(-16, 16) * U / 8;
            if ($urandom_range(0, 1)) begin
              for (int i = 3; i < 6; i++) begin
                dz = t.v[i];
                t.v[i] = t.v[i+3];
                t.v[i+3] = dz;
              end
            end
            foreach (t.v[i]) t.v[i] = sat32(t.v[i]);
          end
          t.mat = 10'($urandom_range(0, 1023));
          t.last = (j == k - 1) || (sent == N_ITEMS - 1);
          send_tri(t, 0);
          if (sent > N_ITEMS - 100) calm = 1;
          if (t.last && sent >= N_ITEMS) break;
        end
      end
    end
    in_valid <= 1'b0;
    while (hit_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errs == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/rtn_pkg.sv
design/rtn_mac.sv
design/rtn_iter.sv
design/ray_triangle_nearest_hit.sv
design/rtn_chk.sv
sim/tb_ray_triangle_nearest_hit.sv
